FILE: rtl/efq_pkg.sv
// Shared types, codes and defaults of the event fan-out queue engine.
package efq_pkg;

	localparam int QUEUES_DEF     = 8;
	localparam int HANDLES_DEF    = 16;
	localparam int RING_DEPTH_DEF = 32;
	localparam int DATA_WIDTH_DEF = 64;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	typedef enum logic [2:0] {
		CMD_INGEST, CMD_CREATE, CMD_DESTROY, CMD_ENABLE,
		CMD_DISABLE, CMD_RATE, CMD_HAS, CMD_READ
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_STATUS, KIND_EVENT, KIND_WAKE, KIND_UPDATE
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK, ST_INVAL, ST_NOFREE, ST_UNSUP
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SENSOR_COUNT, CFG_WAKE_CAP, CFG_BACKEND, CFG_NONE
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_ING, S_SRD, S_SACC, S_SOUT, S_RRD, S_RDAT, S_FIN
	} state_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [3:0]         queue_id;
		logic [4:0]         sensor_handle;
		logic               want_wake;
		logic signed [31:0] req_period;
		logic signed [31:0] req_batch;
		logic [5:0]         read_count;
		logic [63:0]        event_data;
	} efq_in_t;

	typedef struct packed {
		kind_t       kind;
		status_t     status;
		logic [5:0]  value;
		logic [3:0]  out_queue;
		logic [3:0]  out_handle;
		logic [63:0] out_data;
		logic        drive_enable;
		logic        enable_changed;
		logic [30:0] drive_period;
		logic [30:0] drive_batch;
		logic        rate_changed;
		logic        last;
	} efq_out_t;

	typedef struct packed {
		logic clr;
		logic step;
		logic hit;
	} agg_ctl_t;

	// Negative requests mean default or no batching and are kept as zero.
	function automatic logic [30:0] clamp_req(input logic signed [31:0] v);
		return v[31] ? 31'd0 : v[30:0];
	endfunction

endpackage

FILE: rtl/efq_ram.sv
// Single-port-write, registered-read memory used for rings and rate tables.
module efq_ram #(
	parameter int DEPTH = 2,
	parameter int DW = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/efq_agg.sv
// Shared accumulate-and-compare unit for the per-handle aggregate scan.
module efq_agg (
	input  logic              clk,
	input  logic              arst_n,
	input  efq_pkg::agg_ctl_t ctl,
	input  logic [30:0]       period,
	input  logic [30:0]       batch,
	output logic              any_q,
	output logic [30:0]       per_q,
	output logic [30:0]       bat_q
);
	import efq_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q <= 1'b0;
			per_q <= '0;
			bat_q <= '0;
		end else if (ctl.clr) begin
			any_q <= 1'b0;
			per_q <= '0;
			bat_q <= '0;
		end else if (ctl.step && ctl.hit) begin
			any_q <= 1'b1;
			// Zero means no request; keep the smallest nonzero value.
			if (period != '0 && (per_q == '0 || period < per_q)) begin
				per_q <= period;
			end
			if (batch != '0 && (bat_q == '0 || batch < bat_q)) begin
				bat_q <= batch;
			end
		end
	end
endmodule

FILE: rtl/event_fanout_queue_engine_top.sv
// Ingest visits every queue in turn, each aggregate scan folds in every queue per handle,
// and a read emits one event word per event drained. The sequencer, the shared aggregate
// unit and the ring memory port set the pace; one input word is taken at a time, and
// the input stalls until a command's last result word has moved to the output register.
// Reset clears all control state, flags, pointers and rate valid bits at once;
// the ring memory holds no reset value and no clearing pass is run.
module event_fanout_queue_engine_top #(
	parameter int QUEUES     = efq_pkg::QUEUES_DEF,
	parameter int HANDLES    = efq_pkg::HANDLES_DEF,
	parameter int RING_DEPTH = efq_pkg::RING_DEPTH_DEF,
	parameter int DATA_WIDTH = efq_pkg::DATA_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  efq_pkg::efq_in_t               in_word,
	output logic                           out_valid,
	input  logic                           out_stall,
	output efq_pkg::efq_out_t              out_word,
	input  logic                           cfg_we,
	input  logic [efq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [efq_pkg::CFG_DATA_W-1:0] cfg_data
);
	import efq_pkg::*;

	localparam int QW  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
	localparam int HW  = (HANDLES > 1) ? $clog2(HANDLES) : 1;
	localparam int RW  = $clog2(RING_DEPTH);
	localparam int FW  = $clog2(RING_DEPTH + 1);
	localparam int PN  = QUEUES * HANDLES;
	localparam int PAW = (PN > 1) ? $clog2(PN) : 1;
	localparam int RN  = QUEUES * RING_DEPTH;
	localparam int RAW = $clog2(RN);
	localparam int RDW = DATA_WIDTH + 4;

	state_t state_q, state_d;
	efq_in_t item_q;
	logic [4:0] sc_q;
	logic wcap_q, bk_q;

	logic [QUEUES-1:0] used_q, wake_q, armed_q;
	logic [HANDLES-1:0] mask_q [QUEUES];
	logic [RW-1:0] head_q [QUEUES];
	logic [RW-1:0] tail_q [QUEUES];
	logic [FW-1:0] fill_q [QUEUES];
	logic [30:0] drv_per_q [HANDLES];
	logic [HANDLES-1:0] drv_on_q;
	logic [PN-1:0] pb_vld_q;
	logic pbv_q;

	logic [QW-1:0] q_q;
	logic [HW-1:0] h_q;
	logic [5:0] got_q;

	efq_out_t hold_q, out_q, res_d, hold_last;
	logic hold_vld_q, out_vld_q;

	// Sequencer strobes.
	logic emit, step_ok, out_free, push_last;
	logic do_create, do_clear, do_mset, do_mclr, do_rate, do_disarm;
	logic do_ing, do_pop, do_sync;
	logic q_zero, q_inc, h_zero, h_inc, got_zero, got_inc;
	logic [QW-1:0] clr_idx;
	agg_ctl_t agg_ctl;

	logic [5:0] vh;
	logic hvalid, qok, cur_hit, free_found;
	logic [QW-1:0] free_idx;
	logic [PAW-1:0] pb_addr;
	logic [RAW-1:0] ring_waddr, ring_raddr;
	logic [61:0] pb_rdata;
	logic [RDW-1:0] ring_rdata;
	logic agg_any, rch, ech;
	logic [30:0] agg_per, agg_bat;

	function automatic logic [RW-1:0] ring_inc(input logic [RW-1:0] p);
		return (p == RW'(RING_DEPTH - 1)) ? '0 : RW'(p + 1'b1);
	endfunction

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_vld_q;
	assign out_word  = out_q;

	assign vh = ({1'b0, sc_q} > 6'(HANDLES)) ? 6'(HANDLES) : {1'b0, sc_q};
	assign hvalid = {1'b0, item_q.sensor_handle} < vh;
	assign qok = ({1'b0, item_q.queue_id} < 5'(QUEUES)) && used_q[q_q];
	assign cur_hit = used_q[q_q] && mask_q[q_q][h_q];

	always_comb begin
		hold_last = hold_q;
		hold_last.last = 1'b1;
	end

	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = QUEUES - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_found = 1'b1;
				free_idx = QW'(i);
			end
		end
	end

	assign pb_addr    = PAW'(PAW'(q_q) * PAW'(HANDLES) + PAW'(h_q));
	assign ring_waddr = RAW'(RAW'(q_q) * RAW'(RING_DEPTH) + RAW'(head_q[q_q]));
	assign ring_raddr = RAW'(RAW'(q_q) * RAW'(RING_DEPTH) + RAW'(tail_q[q_q]));

	efq_ram #(.DEPTH(PN), .DW(62)) u_rate_ram (
		.clk   (clk),
		.we    (do_rate),
		.waddr (pb_addr),
		.wdata ({clamp_req(item_q.req_period), clamp_req(item_q.req_batch)}),
		.raddr (pb_addr),
		.rdata (pb_rdata)
	);

	efq_ram #(.DEPTH(RN), .DW(RDW)) u_ring_ram (
		.clk   (clk),
		.we    (do_ing),
		.waddr (ring_waddr),
		.wdata ({item_q.sensor_handle[3:0], item_q.event_data[DATA_WIDTH-1:0]}),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	efq_agg u_agg (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (agg_ctl),
		.period (pbv_q ? pb_rdata[61:31] : 31'd0),
		.batch  (pbv_q ? pb_rdata[30:0] : 31'd0),
		.any_q  (agg_any),
		.per_q  (agg_per),
		.bat_q  (agg_bat)
	);

	assign rch = (agg_per != '0) && (agg_per != drv_per_q[h_q]);
	assign ech = agg_any != drv_on_q[h_q];

	assign out_free = !out_vld_q || !out_stall;
	assign step_ok  = !hold_vld_q || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		emit = 1'b0;
		res_d = '0;
		push_last = 1'b0;
		{do_create, do_clear, do_mset, do_mclr, do_rate, do_disarm} = '0;
		{do_ing, do_pop, do_sync} = '0;
		{q_zero, q_inc, h_zero, h_inc, got_zero, got_inc} = '0;
		clr_idx = q_q;
		agg_ctl = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DEC;
			end
			S_DEC: begin
				if (step_ok) begin
					unique case (item_q.cmd)
						CMD_INGEST: begin
							q_zero = 1'b1;
							state_d = hvalid ? S_ING : S_FIN;
						end
						CMD_CREATE: begin
							emit = 1'b1;
							state_d = S_FIN;
							if (!bk_q) begin
								res_d.status = ST_UNSUP;
							end else if (!free_found) begin
								res_d.status = ST_NOFREE;
							end else begin
								do_create = 1'b1;
								do_clear = 1'b1;
								clr_idx = free_idx;
								res_d.value = 6'(free_idx);
							end
						end
						CMD_DESTROY: begin
							emit = 1'b1;
							if (!qok) begin
								res_d.status = ST_INVAL;
								state_d = S_FIN;
							end else begin
								do_clear = 1'b1;
								q_zero = 1'b1;
								h_zero = 1'b1;
								agg_ctl.clr = 1'b1;
								state_d = (vh == '0) ? S_FIN : S_SRD;
							end
						end
						CMD_ENABLE, CMD_DISABLE, CMD_RATE: begin
							emit = 1'b1;
							if (!qok || !hvalid) begin
								res_d.status = ST_INVAL;
								state_d = S_FIN;
							end else begin
								do_mset = (item_q.cmd == CMD_ENABLE);
								do_mclr = (item_q.cmd == CMD_DISABLE);
								do_rate = (item_q.cmd == CMD_RATE);
								q_zero = 1'b1;
								agg_ctl.clr = 1'b1;
								state_d = S_SRD;
							end
						end
						CMD_HAS: begin
							emit = 1'b1;
							state_d = S_FIN;
							if (!qok) begin
								res_d.status = ST_INVAL;
							end else begin
								do_disarm = 1'b1;
								res_d.value = 6'(fill_q[q_q] != '0);
							end
						end
						CMD_READ: begin
							if (item_q.read_count == '0) begin
								emit = 1'b1;
								res_d.status = ST_INVAL;
								state_d = S_FIN;
							end else if (!qok) begin
								emit = 1'b1;
								state_d = S_FIN;
							end else begin
								got_zero = 1'b1;
								state_d = S_RRD;
							end
						end
						default: state_d = S_FIN;
					endcase
				end
			end
			S_ING: begin
				if (step_ok) begin
					if (cur_hit) begin
						do_ing = 1'b1;
						if (!armed_q[q_q] && wake_q[q_q]) begin
							emit = 1'b1;
							res_d.kind = KIND_WAKE;
							res_d.out_queue = 4'(q_q);
						end
					end
					if (q_q == QW'(QUEUES - 1)) state_d = S_FIN;
					else q_inc = 1'b1;
				end
			end
			S_SRD: state_d = S_SACC;
			S_SACC: begin
				agg_ctl.step = 1'b1;
				agg_ctl.hit = cur_hit;
				if (q_q == QW'(QUEUES - 1)) begin
					state_d = S_SOUT;
				end else begin
					q_inc = 1'b1;
					state_d = S_SRD;
				end
			end
			S_SOUT: begin
				if (step_ok) begin
					if (bk_q && (rch || ech)) begin
						do_sync = 1'b1;
						emit = 1'b1;
						res_d.kind = KIND_UPDATE;
						res_d.out_handle = 4'(h_q);
						res_d.drive_enable = agg_any;
						res_d.enable_changed = ech;
						res_d.drive_period = agg_per;
						res_d.drive_batch = agg_bat;
						res_d.rate_changed = rch;
					end
					// A destroy rescans every valid handle in order.
					if (item_q.cmd == CMD_DESTROY && (6'(h_q) + 6'd1) < vh) begin
						h_inc = 1'b1;
						q_zero = 1'b1;
						agg_ctl.clr = 1'b1;
						state_d = S_SRD;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_RRD: begin
				if (step_ok) begin
					if (got_q == item_q.read_count || fill_q[q_q] == '0) begin
						do_disarm = 1'b1;
						emit = 1'b1;
						res_d.value = got_q;
						state_d = S_FIN;
					end else begin
						state_d = S_RDAT;
					end
				end
			end
			S_RDAT: begin
				if (step_ok) begin
					do_pop = 1'b1;
					got_inc = 1'b1;
					emit = 1'b1;
					res_d.kind = KIND_EVENT;
					res_d.out_queue = 4'(q_q);
					res_d.out_handle = ring_rdata[RDW-1:DATA_WIDTH];
					res_d.out_data = 64'(ring_rdata[DATA_WIDTH-1:0]);
					state_d = S_RRD;
				end
			end
			S_FIN: begin
				if (!hold_vld_q) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					push_last = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// The newest result waits in the hold register until the next one shows whether it is last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (emit) hold_vld_q <= 1'b1;
			else if (push_last) hold_vld_q <= 1'b0;
			if ((emit && hold_vld_q) || push_last) out_vld_q <= 1'b1;
			else if (!out_stall) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) hold_q <= res_d;
		if (emit && hold_vld_q) begin
			out_q <= hold_q;
		end else if (push_last) begin
			out_q <= hold_last;
		end
		if (state_q == S_IDLE && in_valid) item_q <= in_word;
		pbv_q <= pb_vld_q[pb_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q <= '0;
			wcap_q <= 1'b0;
			bk_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SENSOR_COUNT: sc_q <= cfg_data[4:0];
				CFG_WAKE_CAP:     wcap_q <= cfg_data[0];
				CFG_BACKEND:      bk_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q <= '0;
			h_q <= '0;
			got_q <= '0;
		end else begin
			if (state_q == S_IDLE && in_valid) begin
				q_q <= in_word.queue_id[QW-1:0];
				h_q <= in_word.sensor_handle[HW-1:0];
			end else if (q_zero) begin
				q_q <= '0;
			end else if (q_inc) begin
				q_q <= QW'(q_q + 1'b1);
			end
			if (h_zero) h_q <= '0;
			else if (h_inc) h_q <= HW'(h_q + 1'b1);
			if (got_zero) got_q <= '0;
			else if (got_inc) got_q <= got_q + 6'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			wake_q <= '0;
			armed_q <= '0;
			pb_vld_q <= '0;
			drv_on_q <= '0;
			for (int i = 0; i < QUEUES; i++) begin
				mask_q[i] <= '0;
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
			for (int i = 0; i < HANDLES; i++) drv_per_q[i] <= '0;
		end else begin
			if (do_clear) begin
				used_q[clr_idx] <= do_create;
				wake_q[clr_idx] <= do_create && item_q.want_wake && wcap_q;
				armed_q[clr_idx] <= 1'b0;
				mask_q[clr_idx] <= '0;
				head_q[clr_idx] <= '0;
				tail_q[clr_idx] <= '0;
				fill_q[clr_idx] <= '0;
				for (int i = 0; i < HANDLES; i++) begin
					pb_vld_q[PAW'(PAW'(clr_idx) * PAW'(HANDLES) + PAW'(i))] <= 1'b0;
				end
			end
			if (do_mset) mask_q[q_q][h_q] <= 1'b1;
			if (do_mclr) mask_q[q_q][h_q] <= 1'b0;
			if (do_rate) pb_vld_q[pb_addr] <= 1'b1;
			if (do_disarm) armed_q[q_q] <= 1'b0;
			if (do_ing) begin
				head_q[q_q] <= ring_inc(head_q[q_q]);
				// A full ring drops its oldest word.
				if (fill_q[q_q] == FW'(RING_DEPTH)) tail_q[q_q] <= ring_inc(tail_q[q_q]);
				else fill_q[q_q] <= FW'(fill_q[q_q] + 1'b1);
				if (wake_q[q_q]) armed_q[q_q] <= 1'b1;
			end
			if (do_pop) begin
				tail_q[q_q] <= ring_inc(tail_q[q_q]);
				fill_q[q_q] <= FW'(fill_q[q_q] - 1'b1);
			end
			if (do_sync) begin
				if (rch) drv_per_q[h_q] <= agg_per;
				if (ech) drv_on_q[h_q] <= agg_any;
			end
		end
	end
endmodule

FILE: rtl/efq_chk.sv
// Port-level checker for the event fan-out queue engine, bound to the top level.
module efq_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input efq_pkg::efq_out_t out_word
);
	import efq_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("stalled output word changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after accept");

	a_event_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.kind == KIND_EVENT |->
		out_word.status == ST_OK && !out_word.enable_changed && !out_word.rate_changed)
		else $error("event word carries status or update fields");

	a_update_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.kind == KIND_UPDATE |->
		out_word.enable_changed || out_word.rate_changed)
		else $error("backend update without a change");
endmodule

bind event_fanout_queue_engine_top efq_chk u_efq_chk (.*);

FILE: tb/tb_top.sv
// Self-checking testbench of the event fan-out queue engine with its own predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import efq_pkg::*;

	localparam int NQ = QUEUES_DEF;
	localparam int NH = HANDLES_DEF;
	localparam int DEPTH = RING_DEPTH_DEF;
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE = 40;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	efq_in_t in_word;
	logic out_valid;
	logic out_stall;
	efq_out_t out_word;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	event_fanout_queue_engine_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predicted engine state.
	int unsigned sensors;
	bit wake_cap;
	bit backend_on;
	bit q_used[NQ];
	bit q_wake[NQ];
	bit q_armed[NQ];
	bit [15:0] q_mask[NQ];
	bit [30:0] q_period[NQ][NH];
	bit [30:0] q_batch[NQ][NH];
	bit [63:0] ring_data[NQ][DEPTH];
	bit [3:0] ring_handle[NQ][DEPTH];
	int unsigned r_head[NQ];
	int unsigned r_tail[NQ];
	int unsigned r_fill[NQ];
	bit [30:0] drv_period[NH];
	bit drv_on[NH];

	efq_out_t pending_results[$];
	efq_out_t run_words[$];
	int errors;
	int max_gap;
	int hold_cycles;
	bit in_take;
	bit out_take;
	efq_out_t out_seen;
	int idle_count;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_word <= '0;
		out_stall <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic int unsigned live_handles();
		return sensors > NH ? NH : sensors;
	endfunction

	function automatic void push_status(status_t st, int unsigned val);
		efq_out_t r;
		r = '0;
		r.kind = KIND_STATUS;
		r.status = st;
		r.value = val[5:0];
		run_words.push_back(r);
	endfunction

	function automatic void clear_queue(int unsigned q);
		q_used[q] = 1'b0;
		q_wake[q] = 1'b0;
		q_armed[q] = 1'b0;
		q_mask[q] = '0;
		for (int h = 0; h < NH; h++) begin
			q_period[q][h] = '0;
			q_batch[q][h] = '0;
		end
		r_head[q] = 0;
		r_tail[q] = 0;
		r_fill[q] = 0;
	endfunction

	// Fold every subscriber of a handle into the driven backend state.
	function automatic void resync_handle(int unsigned h);
		bit any;
		bit [30:0] per;
		bit [30:0] bat;
		bit ech;
		bit rch;
		efq_out_t r;
		any = 1'b0;
		per = '0;
		bat = '0;
		for (int q = 0; q < NQ; q++) begin
			if (q_used[q] && q_mask[q][h]) begin
				any = 1'b1;
				if (q_period[q][h] != 0 && (per == 0 || q_period[q][h] < per))
					per = q_period[q][h];
				if (q_batch[q][h] != 0 && (bat == 0 || q_batch[q][h] < bat))
					bat = q_batch[q][h];
			end
		end
		if (!backend_on)
			return;
		rch = per != 0 && per != drv_period[h];
		ech = any != drv_on[h];
		if (!rch && !ech)
			return;
		if (rch)
			drv_period[h] = per;
		if (ech)
			drv_on[h] = any;
		r = '0;
		r.kind = KIND_UPDATE;
		r.out_handle = h[3:0];
		r.drive_enable = any;
		r.enable_changed = ech;
		r.drive_period = per;
		r.drive_batch = bat;
		r.rate_changed = rch;
		run_words.push_back(r);
	endfunction

	function automatic void model_command(efq_in_t w);
		int unsigned id;
		int unsigned h;
		bit hvalid;
		bit qok;
		bit [30:0] per;
		bit [30:0] bat;
		int unsigned got;
		int unsigned q;
		efq_out_t r;
		id = 32'(w.queue_id);
		h = 32'(w.sensor_handle);
		hvalid = h < live_handles();
		qok = id < NQ && q_used[id];
		per = w.req_period[31] ? 31'd0 : w.req_period[30:0];
		bat = w.req_batch[31] ? 31'd0 : w.req_batch[30:0];
		run_words.delete();
		case (w.cmd)
			CMD_INGEST: begin
				if (hvalid) begin
					for (q = 0; q < NQ; q++) begin
						if (!q_used[q] || !q_mask[q][h])
							continue;
						if (r_fill[q] >= DEPTH) begin
							r_tail[q] = (r_tail[q] + 1) % DEPTH;
							r_fill[q] = DEPTH - 1;
						end
						ring_data[q][r_head[q]] = w.event_data;
						ring_handle[q][r_head[q]] = h[3:0];
						r_head[q] = (r_head[q] + 1) % DEPTH;
						r_fill[q]++;
						if (!q_armed[q] && q_wake[q]) begin
							q_armed[q] = 1'b1;
							r = '0;
							r.kind = KIND_WAKE;
							r.out_queue = q[3:0];
							run_words.push_back(r);
						end
					end
				end
			end
			CMD_CREATE: begin
				if (!backend_on)
					push_status(ST_UNSUP, 0);
				else begin
					for (q = 0; q < NQ; q++)
						if (!q_used[q])
							break;
					if (q >= NQ)
						push_status(ST_NOFREE, 0);
					else begin
						clear_queue(q);
						q_used[q] = 1'b1;
						q_wake[q] = w.want_wake && wake_cap;
						push_status(ST_OK, q);
					end
				end
			end
			CMD_DESTROY: begin
				if (!qok)
					push_status(ST_INVAL, 0);
				else begin
					clear_queue(id);
					push_status(ST_OK, 0);
					for (int unsigned k = 0; k < live_handles(); k++)
						resync_handle(k);
				end
			end
			CMD_ENABLE, CMD_DISABLE, CMD_RATE: begin
				if (!qok || !hvalid)
					push_status(ST_INVAL, 0);
				else begin
					if (w.cmd == CMD_ENABLE)
						q_mask[id][h] = 1'b1;
					else if (w.cmd == CMD_DISABLE)
						q_mask[id][h] = 1'b0;
					else begin
						q_period[id][h] = per;
						q_batch[id][h] = bat;
					end
					push_status(ST_OK, 0);
					resync_handle(h);
				end
			end
			CMD_HAS: begin
				if (!qok)
					push_status(ST_INVAL, 0);
				else begin
					q_armed[id] = 1'b0;
					push_status(ST_OK, r_fill[id] > 0 ? 1 : 0);
				end
			end
			default: begin
				if (w.read_count == 0)
					push_status(ST_INVAL, 0);
				else if (!qok)
					push_status(ST_OK, 0);
				else begin
					got = 0;
					while (got < w.read_count && r_fill[id] > 0) begin
						r = '0;
						r.kind = KIND_EVENT;
						r.out_queue = id[3:0];
						r.out_handle = ring_handle[id][r_tail[id]];
						r.out_data = ring_data[id][r_tail[id]];
						r_tail[id] = (r_tail[id] + 1) % DEPTH;
						r_fill[id]--;
						got++;
						run_words.push_back(r);
					end
					q_armed[id] = 1'b0;
					push_status(ST_OK, got);
				end
			end
		endcase
		if (run_words.size() > 0)
			run_words[run_words.size() - 1].last = 1'b1;
		foreach (run_words[i])
			pending_results.push_back(run_words[i]);
	endfunction

	// Both handshakes are sampled mid-cycle, where nothing is changing.
	always @(negedge clk) begin
		in_take <= in_valid && !in_stall;
		out_take <= out_valid && !out_stall;
		out_seen <= out_word;
	end

	always @(posedge clk) begin
		efq_out_t e;
		if (out_take) begin
			if (pending_results.size() == 0)
				report_mismatch("unexpected word", out_seen.out_data, '0);
			else begin
				e = pending_results.pop_front();
				if (out_seen.kind != e.kind)
					report_mismatch("kind", 64'(out_seen.kind), 64'(e.kind));
				if (out_seen.status != e.status)
					report_mismatch("status", 64'(out_seen.status), 64'(e.status));
				if (out_seen.value != e.value)
					report_mismatch("value", 64'(out_seen.value), 64'(e.value));
				if (out_seen.out_queue != e.out_queue)
					report_mismatch("out_queue", 64'(out_seen.out_queue),
						64'(e.out_queue));
				if (out_seen.out_handle != e.out_handle)
					report_mismatch("out_handle", 64'(out_seen.out_handle),
						64'(e.out_handle));
				if (out_seen.out_data != e.out_data)
					report_mismatch("out_data", out_seen.out_data, e.out_data);
				if (out_seen.drive_enable != e.drive_enable)
					report_mismatch("drive_enable", 64'(out_seen.drive_enable),
						64'(e.drive_enable));
				if (out_seen.enable_changed != e.enable_changed)
					report_mismatch("enable_changed", 64'(out_seen.enable_changed),
						64'(e.enable_changed));
				if (out_seen.drive_period != e.drive_period)
					report_mismatch("drive_period", 64'(out_seen.drive_period),
						64'(e.drive_period));
				if (out_seen.drive_batch != e.drive_batch)
					report_mismatch("drive_batch", 64'(out_seen.drive_batch),
						64'(e.drive_batch));
				if (out_seen.rate_changed != e.rate_changed)
					report_mismatch("rate_changed", 64'(out_seen.rate_changed),
						64'(e.rate_changed));
				if (out_seen.last != e.last)
					report_mismatch("last", 64'(out_seen.last), 64'(e.last));
			end
		end
	end

	always @(posedge clk) begin
		if (in_take || out_take)
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Receiver: random stalls per word, with an occasional long hold-off.
	initial begin
		int n;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				n = hold_cycles;
				hold_cycles = 0;
			end else
				n = max_gap == 0 ? 0 : $urandom_range(0, max_gap);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!out_take && hold_cycles == 0);
		end
	end

	// Called at a rising edge; returns at the edge where the word was taken.
	task automatic send_word(input efq_in_t w);
		int gap;
		gap = max_gap == 0 ? 0 : $urandom_range(0, max_gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do
			@(negedge clk);
		while (in_stall);
		@(posedge clk);
		model_command(w);
	endtask

	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Leaves the write enable high; the caller drops it after the last write.
	task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		@(posedge clk);
		case (idx)
			CFG_SENSOR_COUNT: sensors = val & 31;
			CFG_WAKE_CAP: wake_cap = val[0];
			CFG_BACKEND: backend_on = val[0];
			default: ;
		endcase
	endtask

	task automatic setup(input int unsigned ns, input bit wc, input bit bp);
		write_reg(CFG_SENSOR_COUNT, ns);
		write_reg(CFG_WAKE_CAP, wc);
		write_reg(CFG_BACKEND, bp);
		cfg_we <= 1'b0;
	endtask

	function automatic efq_in_t make_cmd(cmd_t c, int unsigned id, int unsigned h);
		efq_in_t w;
		w = '0;
		w.cmd = c;
		w.queue_id = id[3:0];
		w.sensor_handle = h[4:0];
		w.read_count = 6'd63;
		return w;
	endfunction

	function automatic logic [31:0] rand_request();
		case ($urandom_range(0, 3))
			0: return $urandom_range(1, 1000);
			1: return 32'h8000_0000 | $urandom;
			2: return 32'd0;
			default: return $urandom;
		endcase
	endfunction

	function automatic efq_in_t rand_cmd();
		efq_in_t w;
		int p;
		w = '0;
		p = $urandom_range(0, 99);
		if (p < 40) w.cmd = CMD_INGEST;
		else if (p < 48) w.cmd = CMD_CREATE;
		else if (p < 52) w.cmd = CMD_DESTROY;
		else if (p < 66) w.cmd = CMD_ENABLE;
		else if (p < 71) w.cmd = CMD_DISABLE;
		else if (p < 80) w.cmd = CMD_RATE;
		else if (p < 87) w.cmd = CMD_HAS;
		else w.cmd = CMD_READ;
		w.queue_id = 4'($urandom_range(0, 9) == 0 ? $urandom_range(0, 15) :
			$urandom_range(0, NQ - 1));
		w.sensor_handle = 5'($urandom_range(0, 9) == 0 ? $urandom_range(0, 31) :
			$urandom_range(0, 3));
		w.want_wake = 1'($urandom_range(0, 1));
		w.req_period = rand_request();
		w.req_batch = rand_request();
		p = $urandom_range(0, 19);
		w.read_count = p == 0 ? 6'd0 :
			6'(p < 4 ? $urandom_range(0, 63) : $urandom_range(1, 8));
		w.event_data = {$urandom, $urandom};
		return w;
	endfunction

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) begin
			max_gap = (i / 20) % 3 == 2 ? 0 : 16;
			send_word(rand_cmd());
		end
		drain_and_settle();
	endtask

	// Without a backend, create is refused and invalid requests are answered.
	task automatic test_no_backend();
		efq_in_t w;
		send_word(make_cmd(CMD_CREATE, 0, 0));
		send_word(make_cmd(CMD_HAS, 0, 0));
		send_word(make_cmd(CMD_READ, 15, 0));
		w = make_cmd(CMD_READ, 0, 0);
		w.read_count = 6'd0;
		send_word(w);
		send_word(make_cmd(CMD_ENABLE, 3, 31));
		send_word(make_cmd(CMD_DESTROY, 7, 0));
		drain_and_settle();
	endtask

	task automatic test_directed();
		efq_in_t w;
		for (int q = 0; q <= NQ; q++) begin
			w = make_cmd(CMD_CREATE, 0, 0);
			w.want_wake = q[0];
			send_word(w);
		end
		send_word(make_cmd(CMD_ENABLE, 1, 15));
		send_word(make_cmd(CMD_ENABLE, 2, 15));
		send_word(make_cmd(CMD_ENABLE, 1, 16));
		send_word(make_cmd(CMD_ENABLE, 8, 0));
		w = make_cmd(CMD_RATE, 1, 15);
		w.req_period = 32'h7FFF_FFFF;
		w.req_batch = 32'h7FFF_FFFF;
		send_word(w);
		w.queue_id = 4'd2;
		w.req_period = 32'sd1;
		w.req_batch = 32'h8000_0000;
		send_word(w);
		w = make_cmd(CMD_INGEST, 0, 15);
		w.event_data = '1;
		send_word(w);
		w.event_data = '0;
		send_word(w);
		send_word(make_cmd(CMD_HAS, 1, 0));
		w = make_cmd(CMD_READ, 1, 0);
		w.read_count = 6'd1;
		send_word(w);
		send_word(make_cmd(CMD_READ, 2, 0));
		send_word(make_cmd(CMD_DISABLE, 2, 15));
		send_word(make_cmd(CMD_DESTROY, 1, 0));
		send_word(make_cmd(CMD_DESTROY, 15, 0));
		drain_and_settle();
	endtask

	// The receiver holds off while words keep coming, so the engine backs up.
	task automatic test_backpressure();
		hold_cycles = 300;
		max_gap = 0;
		for (int i = 0; i < 30; i++)
			send_word(rand_cmd());
		drain_and_settle();
	endtask

	initial begin
		errors = 0;
		max_gap = 16;
		hold_cycles = 0;
		sensors = 0;
		wake_cap = 1'b0;
		backend_on = 1'b0;
		for (int q = 0; q < NQ; q++)
			clear_queue(q);
		for (int h = 0; h < NH; h++) begin
			drv_period[h] = '0;
			drv_on[h] = 1'b0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_no_backend();
		setup(16, 1, 1);
		test_directed();
		run_random(90);
		setup(31, 0, 1);
		run_random(60);
		test_backpressure();
		setup(5, 1, 0);
		run_random(50);
		setup(0, 1, 1);
		run_random(20);
		setup(16, 1, 1);
		run_random(60);
		repeat (300) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("words never delivered", 64'(pending_results.size()), '0);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: files.f
rtl/efq_pkg.sv
rtl/efq_ram.sv
rtl/efq_agg.sv
rtl/event_fanout_queue_engine_top.sv
rtl/efq_chk.sv
tb/tb_top.sv
